// File: rtl/core/rqv_pkg.sv
// shared types, constants and the cordic arctangent table for the rotated quad vertex generator
package rqv_pkg;

   // default geometry
   localparam int COORD_BITS_DEF   = 32;
   localparam int UV_BITS_DEF      = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // cordic datapath, q2.30 with headroom for the rotation growth
   localparam int CS_BITS     = 34;
   localparam int PHASE_BITS  = 32;
   localparam int ANGLE_BITS  = 16;
   localparam int ATAN_LEN    = 24;
   localparam int ATAN_IDX_W  = 5;
   localparam logic [PHASE_BITS-1:0] CORDIC_GAIN = 32'h26DD3B6A;
   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 16'h4000;

   // corner sum rounding: add half, shift by 31
   localparam int ROUND_SHIFT = 31;

   // uv integer bits; the fraction bits lie below this q4 integer part
   localparam int UV_INT_BITS = 4;

   localparam logic [1:0] LAST_CORNER = 2'd3;

   typedef enum logic [1:0] {
      KIND_CREATE_TEX   = 2'd0,
      KIND_CREATE_COLOR = 2'd1,
      KIND_UPDATE_TEX   = 2'd2,
      KIND_UPDATE_COLOR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SPRITE_NONE  = 2'd0,
      SPRITE_TEX   = 2'd1,
      SPRITE_COLOR = 2'd2
   } sprite_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT,
      ST_MUL,
      ST_SUM,
      ST_EMIT,
      ST_ERR
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   localparam logic [1:0] NSIGN_ZERO = 2'b00;
   localparam logic [1:0] NSIGN_POS  = 2'b01;
   localparam logic [1:0] NSIGN_NEG  = 2'b11;

   // atan(2^-i) as a binary angle, 2^32 per turn
   function automatic logic [PHASE_BITS-1:0] atan_value(input logic [ATAN_IDX_W-1:0] idx);
      logic [PHASE_BITS-1:0] val;
      unique case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/rqv_cordic.sv
// iterative cordic rotator: one shift-add step per cycle, gives cos and sin in q2.30
module rqv_cordic #(
   parameter int CORDIC_STEPS = rqv_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [rqv_pkg::ANGLE_BITS-1:0]          angle,
   output logic signed [rqv_pkg::CS_BITS-1:0]      cos_out,
   output logic signed [rqv_pkg::CS_BITS-1:0]      sin_out,
   output rqv_pkg::unit_stat_type                  stat
);

   localparam int CS     = rqv_pkg::CS_BITS;
   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 flip_ff, flip_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic signed [CS-1:0] x_ff, x_in;
   logic signed [CS-1:0] y_ff, y_in;
   logic signed [CS-1:0] z_ff, z_in;
   logic signed [CS-1:0] cos_ff, cos_in;
   logic signed [CS-1:0] sin_ff, sin_in;

   logic [rqv_pkg::ANGLE_BITS-1:0] fold_sum;
   logic [rqv_pkg::ANGLE_BITS-1:0] angle_f;
   logic signed [CS-1:0]           dx, dy, da;
   logic                           z_neg;

   always_comb begin
      fold_sum = angle + rqv_pkg::QUARTER_TURN;
      angle_f  = {angle[rqv_pkg::ANGLE_BITS-1] ^ fold_sum[rqv_pkg::ANGLE_BITS-1],
                  angle[rqv_pkg::ANGLE_BITS-2:0]};
      dx    = y_ff >>> step_ff;
      dy    = x_ff >>> step_ff;
      da    = signed'({{(CS-rqv_pkg::PHASE_BITS){1'b0}},
                       rqv_pkg::atan_value(rqv_pkg::ATAN_IDX_W'(step_ff))});
      z_neg = z_ff[CS-1];

      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;

      if (start) begin
         busy_in = 1'b1;
         flip_in = fold_sum[rqv_pkg::ANGLE_BITS-1];
         step_in = '0;
         x_in    = signed'(CS'(rqv_pkg::CORDIC_GAIN));
         y_in    = '0;
         z_in    = signed'({{(CS-rqv_pkg::PHASE_BITS){angle_f[rqv_pkg::ANGLE_BITS-1]}},
                            angle_f, {(rqv_pkg::PHASE_BITS-rqv_pkg::ANGLE_BITS){1'b0}}});
      end else if (busy_ff) begin
         if (z_neg) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + da;
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - da;
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cos_in  = flip_ff ? -x_in : x_in;
            sin_in  = flip_ff ? -y_in : y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in;
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/core/rqv_prod.sv
// shared multiplier: forms w*cos, w*sin, h*cos, h*sin one per cycle
module rqv_prod #(
   parameter int COORD_BITS = rqv_pkg::COORD_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic signed [COORD_BITS-1:0]                  w,
   input  logic signed [COORD_BITS-1:0]                  h,
   input  logic signed [rqv_pkg::CS_BITS-1:0]            c,
   input  logic signed [rqv_pkg::CS_BITS-1:0]            s,
   output logic signed [COORD_BITS+rqv_pkg::CS_BITS-1:0] wc,
   output logic signed [COORD_BITS+rqv_pkg::CS_BITS-1:0] ws,
   output logic signed [COORD_BITS+rqv_pkg::CS_BITS-1:0] hc,
   output logic signed [COORD_BITS+rqv_pkg::CS_BITS-1:0] hs,
   output rqv_pkg::unit_stat_type                        stat
);

   localparam int PROD_W = COORD_BITS + rqv_pkg::CS_BITS;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [1:0]               idx_ff, idx_in;
   logic signed [PROD_W-1:0] p_ff [4];

   logic signed [COORD_BITS-1:0]       a_sel;
   logic signed [rqv_pkg::CS_BITS-1:0] b_sel;
   logic signed [PROD_W-1:0]           prod;

   // idx bit 1 picks height, bit 0 picks sine
   always_comb begin
      a_sel = idx_ff[1] ? h : w;
      b_sel = idx_ff[0] ? s : c;
      prod  = PROD_W'(a_sel) * PROD_W'(b_sel);

      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff) begin
         idx_in = idx_ff + 2'd1;
         if (idx_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      if (busy_ff && !start) begin
         p_ff[idx_ff] <= prod;
      end
   end

   assign wc        = p_ff[0];
   assign ws        = p_ff[1];
   assign hc        = p_ff[2];
   assign hs        = p_ff[3];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/core/rotated_quad_vertex_generator.sv
// top level of the rotated quad vertex generator: sequencer, corner sums and result register
//
// usage
//   req channel: one item per sprite (kind, centre, size, angle, colour, uv window),
//   taken when req_valid and req_ready are high at a rising clock edge
//   rsp channel: four corner items, corner 0 to 3, last set on corner 3; an update
//   whose type differs from the stored sprite gives one item with type_error and last
//   set and all other fields zero
//   steps: cos and sin come from the iterative rotator, then the four products from the
//   shared multiplier, then each corner passes a sum state and an emit state that
//   rounds, adds the centre, saturates and loads the result register
//   flow: one item at a time, req_ready is high only when the sequencer is idle;
//   the next item is taken only after the last corner, or the error item, has been
//   loaded into the result register
//   the result register parts the two sides: the next item is taken while the last
//   corner still waits; a stalled receiver holds the sequencer at the next corner
//   reset: synchronous, clears the sequencer, the result valid and the stored sprite
//   type (no sprite), with stored width and height zero
module rotated_quad_vertex_generator #(
   parameter int COORD_BITS   = rqv_pkg::COORD_BITS_DEF,
   parameter int UV_BITS      = rqv_pkg::UV_BITS_DEF,
   parameter int CORDIC_STEPS = rqv_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic signed [COORD_BITS-1:0]  req_center_x,
   input  logic signed [COORD_BITS-1:0]  req_center_y,
   input  logic signed [COORD_BITS-1:0]  req_center_z,
   input  logic signed [COORD_BITS-1:0]  req_rect_width,
   input  logic signed [COORD_BITS-1:0]  req_rect_height,
   input  logic [15:0]                   req_angle,
   input  logic [31:0]                   req_color_rgba,
   input  logic signed [UV_BITS-1:0]     req_u_left,
   input  logic signed [UV_BITS-1:0]     req_v_top,
   input  logic signed [UV_BITS-1:0]     req_u_right,
   input  logic signed [UV_BITS-1:0]     req_v_bottom,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS-1:0]  rsp_vertex_x,
   output logic signed [COORD_BITS-1:0]  rsp_vertex_y,
   output logic signed [COORD_BITS-1:0]  rsp_vertex_z,
   output logic signed [UV_BITS-1:0]     rsp_tex_u,
   output logic signed [UV_BITS-1:0]     rsp_tex_v,
   output logic [31:0]                   rsp_vertex_color,
   output logic signed [1:0]             rsp_normal_sign,
   output logic [1:0]                    rsp_corner,
   output logic                          rsp_last,
   output logic                          rsp_type_error
);

   localparam int CS     = rqv_pkg::CS_BITS;
   localparam int PROD_W = COORD_BITS + CS;
   localparam int SUM_W  = PROD_W + 1;
   localparam int HI_W   = SUM_W - COORD_BITS + 1;
   localparam logic signed [SUM_W-1:0] ROUND_HALF =
      signed'(SUM_W'(1) << (rqv_pkg::ROUND_SHIFT - 1));
   localparam logic signed [UV_BITS-1:0] UV_ONE =
      signed'(UV_BITS'(1) << (UV_BITS - rqv_pkg::UV_INT_BITS));
   localparam logic signed [COORD_BITS-1:0] COORD_MAX =
      signed'({1'b0, {(COORD_BITS-1){1'b1}}});
   localparam logic signed [COORD_BITS-1:0] COORD_MIN =
      signed'({1'b1, {(COORD_BITS-1){1'b0}}});

   // sequencer and sprite state
   rqv_pkg::state_type  state_ff, state_in;
   rqv_pkg::sprite_type sprite_kind_ff, sprite_kind_in;
   logic signed [COORD_BITS-1:0] stored_width_ff, stored_width_in;
   logic signed [COORD_BITS-1:0] stored_height_ff, stored_height_in;
   logic [1:0]                   corner_ff, corner_in;

   // item payload held for the whole item
   logic signed [COORD_BITS-1:0] cx_ff, cx_in;
   logic signed [COORD_BITS-1:0] cy_ff, cy_in;
   logic signed [COORD_BITS-1:0] cz_ff, cz_in;
   logic [31:0]                  color_ff, color_in;
   logic signed [UV_BITS-1:0]    ul_ff, ul_in;
   logic signed [UV_BITS-1:0]    vt_ff, vt_in;
   logic signed [UV_BITS-1:0]    ur_ff, ur_in;
   logic signed [UV_BITS-1:0]    vb_ff, vb_in;

   // corner sums
   logic signed [SUM_W-1:0] sx_ff, sx_in;
   logic signed [SUM_W-1:0] sy_ff, sy_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] out_x_ff, out_x_in;
   logic signed [COORD_BITS-1:0] out_y_ff, out_y_in;
   logic signed [COORD_BITS-1:0] out_z_ff, out_z_in;
   logic signed [UV_BITS-1:0]    out_u_ff, out_u_in;
   logic signed [UV_BITS-1:0]    out_v_ff, out_v_in;
   logic [31:0]                  out_color_ff, out_color_in;
   logic [1:0]                   out_nsign_ff, out_nsign_in;
   logic [1:0]                   out_corner_ff, out_corner_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_err_ff, out_err_in;

   // shared units
   logic                     cordic_start, prod_start;
   logic signed [CS-1:0]     cos_val, sin_val;
   logic signed [PROD_W-1:0] wc, ws, hc, hs;
   rqv_pkg::unit_stat_type   cordic_stat, prod_stat;

   // decode and corner datapath
   rqv_pkg::kind_type   kind;
   rqv_pkg::sprite_type want;
   logic                is_update, is_color, mismatch, accept, out_free;
   logic                ax_neg, bx_neg;
   logic signed [SUM_W-1:0] wc_e, ws_e, hc_e, hs_e;
   logic signed [SUM_W-1:0] rnd_x, rnd_y, sh_x, sh_y, pos_x, pos_y;
   logic signed [COORD_BITS-1:0] sat_x, sat_y;
   logic [HI_W-1:0]         hi_x, hi_y;
   logic [1:0]              nsign;

   rqv_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (req_angle),
      .cos_out (cos_val),
      .sin_out (sin_val),
      .stat    (cordic_stat)
   );

   rqv_prod #(
      .COORD_BITS (COORD_BITS)
   ) u_prod (
      .clock (clock),
      .reset (reset),
      .start (prod_start),
      .w     (stored_width_ff),
      .h     (stored_height_ff),
      .c     (cos_val),
      .s     (sin_val),
      .wc    (wc),
      .ws    (ws),
      .hc    (hc),
      .hs    (hs),
      .stat  (prod_stat)
   );

   // item kind decode
   always_comb begin
      kind = rqv_pkg::kind_type'(req_kind);
      unique case (kind)
         rqv_pkg::KIND_CREATE_TEX: begin
            is_update = 1'b0;
            is_color  = 1'b0;
         end
         rqv_pkg::KIND_CREATE_COLOR: begin
            is_update = 1'b0;
            is_color  = 1'b1;
         end
         rqv_pkg::KIND_UPDATE_TEX: begin
            is_update = 1'b1;
            is_color  = 1'b0;
         end
         rqv_pkg::KIND_UPDATE_COLOR: begin
            is_update = 1'b1;
            is_color  = 1'b1;
         end
         default: begin
            is_update = 1'b0;
            is_color  = 1'b0;
         end
      endcase
      want     = is_color ? rqv_pkg::SPRITE_COLOR : rqv_pkg::SPRITE_TEX;
      mismatch = is_update && (sprite_kind_ff != want);
   end

   assign req_ready = (state_ff == rqv_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // corner signs: width term negative on corners 0 and 1, height term on 0 and 3
   always_comb begin
      ax_neg = !corner_ff[1];
      bx_neg = corner_ff[1] ~^ corner_ff[0];
      wc_e   = SUM_W'(wc);
      ws_e   = SUM_W'(ws);
      hc_e   = SUM_W'(hc);
      hs_e   = SUM_W'(hs);
   end

   // round the corner sum, add the centre and saturate
   always_comb begin
      rnd_x = sx_ff + ROUND_HALF;
      rnd_y = sy_ff + ROUND_HALF;
      sh_x  = rnd_x >>> rqv_pkg::ROUND_SHIFT;
      sh_y  = rnd_y >>> rqv_pkg::ROUND_SHIFT;
      pos_x = sh_x + SUM_W'(cx_ff);
      pos_y = sh_y + SUM_W'(cy_ff);
      hi_x  = pos_x[SUM_W-1:COORD_BITS-1];
      hi_y  = pos_y[SUM_W-1:COORD_BITS-1];
      if ((&hi_x) || !(|hi_x)) begin
         sat_x = pos_x[COORD_BITS-1:0];
      end else begin
         sat_x = pos_x[SUM_W-1] ? COORD_MIN : COORD_MAX;
      end
      if ((&hi_y) || !(|hi_y)) begin
         sat_y = pos_y[COORD_BITS-1:0];
      end else begin
         sat_y = pos_y[SUM_W-1] ? COORD_MIN : COORD_MAX;
      end
   end

   // normal sign is the sign of width times height
   always_comb begin
      if (stored_width_ff == '0 || stored_height_ff == '0) begin
         nsign = rqv_pkg::NSIGN_ZERO;
      end else if (stored_width_ff[COORD_BITS-1] == stored_height_ff[COORD_BITS-1]) begin
         nsign = rqv_pkg::NSIGN_POS;
      end else begin
         nsign = rqv_pkg::NSIGN_NEG;
      end
   end

   // sequencer next state and datapath loads
   always_comb begin
      state_in         = state_ff;
      sprite_kind_in   = sprite_kind_ff;
      stored_width_in  = stored_width_ff;
      stored_height_in = stored_height_ff;
      corner_in        = corner_ff;
      cx_in            = cx_ff;
      cy_in            = cy_ff;
      cz_in            = cz_ff;
      color_in         = color_ff;
      ul_in            = ul_ff;
      vt_in            = vt_ff;
      ur_in            = ur_ff;
      vb_in            = vb_ff;
      sx_in            = sx_ff;
      sy_in            = sy_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      out_x_in         = out_x_ff;
      out_y_in         = out_y_ff;
      out_z_in         = out_z_ff;
      out_u_in         = out_u_ff;
      out_v_in         = out_v_ff;
      out_color_in     = out_color_ff;
      out_nsign_in     = out_nsign_ff;
      out_corner_in    = out_corner_ff;
      out_last_in      = out_last_ff;
      out_err_in       = out_err_ff;
      cordic_start     = 1'b0;
      prod_start       = 1'b0;

      unique case (state_ff)
         rqv_pkg::ST_IDLE: begin
            if (accept) begin
               cx_in    = req_center_x;
               cy_in    = req_center_y;
               cz_in    = req_center_z;
               color_in = req_color_rgba;
               if (is_color) begin
                  // colour sprites span the whole uv square
                  ul_in = '0;
                  vt_in = '0;
                  ur_in = UV_ONE;
                  vb_in = UV_ONE;
               end else begin
                  ul_in = req_u_left;
                  vt_in = req_v_top;
                  ur_in = req_u_right;
                  vb_in = req_v_bottom;
               end
               if (!is_update) begin
                  sprite_kind_in   = want;
                  stored_width_in  = req_rect_width;
                  stored_height_in = req_rect_height;
               end
               if (mismatch) begin
                  state_in = rqv_pkg::ST_ERR;
               end else begin
                  cordic_start = 1'b1;
                  state_in     = rqv_pkg::ST_ROT;
               end
            end
         end
         rqv_pkg::ST_ROT: begin
            if (cordic_stat.done) begin
               prod_start = 1'b1;
               state_in   = rqv_pkg::ST_MUL;
            end
         end
         rqv_pkg::ST_MUL: begin
            if (prod_stat.done) begin
               corner_in = '0;
               state_in  = rqv_pkg::ST_SUM;
            end
         end
         rqv_pkg::ST_SUM: begin
            sx_in    = (ax_neg ? -wc_e : wc_e) + (bx_neg ? -hs_e : hs_e);
            sy_in    = (ax_neg ? ws_e : -ws_e) + (bx_neg ? -hc_e : hc_e);
            state_in = rqv_pkg::ST_EMIT;
         end
         rqv_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_x_in      = sat_x;
               out_y_in      = sat_y;
               out_z_in      = cz_ff;
               out_u_in      = corner_ff[1] ? ur_ff : ul_ff;
               out_v_in      = (corner_ff[1] ~^ corner_ff[0]) ? vb_ff : vt_ff;
               out_color_in  = color_ff;
               out_nsign_in  = nsign;
               out_corner_in = corner_ff;
               out_last_in   = (corner_ff == rqv_pkg::LAST_CORNER);
               out_err_in    = 1'b0;
               if (corner_ff == rqv_pkg::LAST_CORNER) begin
                  state_in = rqv_pkg::ST_IDLE;
               end else begin
                  corner_in = corner_ff + 2'd1;
                  state_in  = rqv_pkg::ST_SUM;
               end
            end
         end
         rqv_pkg::ST_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_x_in      = '0;
               out_y_in      = '0;
               out_z_in      = '0;
               out_u_in      = '0;
               out_v_in      = '0;
               out_color_in  = '0;
               out_nsign_in  = rqv_pkg::NSIGN_ZERO;
               out_corner_in = '0;
               out_last_in   = 1'b1;
               out_err_in    = 1'b1;
               state_in      = rqv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rqv_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rqv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and sprite state
   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_kind_ff   <= rqv_pkg::SPRITE_NONE;
         stored_width_ff  <= '0;
         stored_height_ff <= '0;
         rsp_valid_ff     <= 1'b0;
         corner_ff        <= '0;
      end else begin
         sprite_kind_ff   <= sprite_kind_in;
         stored_width_ff  <= stored_width_in;
         stored_height_ff <= stored_height_in;
         rsp_valid_ff     <= rsp_valid_in;
         corner_ff        <= corner_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      cz_ff         <= cz_in;
      color_ff      <= color_in;
      ul_ff         <= ul_in;
      vt_ff         <= vt_in;
      ur_ff         <= ur_in;
      vb_ff         <= vb_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_z_ff      <= out_z_in;
      out_u_ff      <= out_u_in;
      out_v_ff      <= out_v_in;
      out_color_ff  <= out_color_in;
      out_nsign_ff  <= out_nsign_in;
      out_corner_ff <= out_corner_in;
      out_last_ff   <= out_last_in;
      out_err_ff    <= out_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_x     = out_x_ff;
   assign rsp_vertex_y     = out_y_ff;
   assign rsp_vertex_z     = out_z_ff;
   assign rsp_tex_u        = out_u_ff;
   assign rsp_tex_v        = out_v_ff;
   assign rsp_vertex_color = out_color_ff;
   assign rsp_normal_sign  = signed'(out_nsign_ff);
   assign rsp_corner       = out_corner_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_type_error   = out_err_ff;

`ifndef SYNTH
   // an error item is a single item: last set, corner zero
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_err_ff |-> out_last_ff && (out_corner_ff == '0))
      else $error("error item without last or with nonzero corner");

   // a corner item carries last exactly on the final corner
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_err_ff |-> (out_last_ff == (out_corner_ff == rqv_pkg::LAST_CORNER)))
      else $error("last flag does not match corner number");

   // finished rotation hands straight over to the multiplier
   a_rot_to_mul: assert property (@(posedge clock) disable iff (reset)
      cordic_stat.done && (state_ff == rqv_pkg::ST_ROT) |=> prod_stat.busy)
      else $error("multiplier not started after cordic finished");
`endif

endmodule

// File: tb/rotated_quad_vertex_generator_tb.sv
// self-checking testbench for the rotated quad vertex generator: directed and random sprites
module rotated_quad_vertex_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW          = rqv_pkg::COORD_BITS_DEF;
   localparam int UW          = rqv_pkg::UV_BITS_DEF;
   localparam int STEPS       = rqv_pkg::CORDIC_STEPS_DEF;
   localparam int PERIOD      = 10;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 40;       // settling wait after draining, before the verdict
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   localparam longint GAIN_Q30   = 64'sh26DD3B6A;
   localparam longint ROUND_HALF = 64'sd1 << 30;
   localparam longint COORD_MAX  = (64'sd1 << (CW - 1)) - 1;
   localparam longint COORD_MIN  = -COORD_MAX - 1;

   // atan(2^-i) in turns scaled by 2^32
   localparam logic [31:0] ARCTAN_TURN [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // one sprite request as it goes out on the req channel
   typedef struct {
      rqv_pkg::kind_type       kind;
      logic signed [CW-1:0]    cx;
      logic signed [CW-1:0]    cy;
      logic signed [CW-1:0]    cz;
      logic signed [CW-1:0]    width;
      logic signed [CW-1:0]    height;
      logic [15:0]             angle;
      logic [31:0]             rgba;
      logic signed [UW-1:0]    ul;
      logic signed [UW-1:0]    vt;
      logic signed [UW-1:0]    ur;
      logic signed [UW-1:0]    vb;
   } sprite_req_type;

   // one vertex item as it comes back on the rsp channel
   typedef struct packed {
      logic signed [CW-1:0] vertex_x;
      logic signed [CW-1:0] vertex_y;
      logic signed [CW-1:0] vertex_z;
      logic signed [UW-1:0] tex_u;
      logic signed [UW-1:0] tex_v;
      logic [31:0]          color;
      logic signed [1:0]    normal_sign;
      logic [1:0]           corner;
      logic                 last;
      logic                 type_error;
   } vertex_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #(PERIOD / 2) clock = ~clock;

   // block ports; the driven inputs are known from time zero
   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_kind        = '0;
   logic signed [CW-1:0] req_center_x    = '0;
   logic signed [CW-1:0] req_center_y    = '0;
   logic signed [CW-1:0] req_center_z    = '0;
   logic signed [CW-1:0] req_rect_width  = '0;
   logic signed [CW-1:0] req_rect_height = '0;
   logic [15:0]          req_angle       = '0;
   logic [31:0]          req_color_rgba  = '0;
   logic signed [UW-1:0] req_u_left      = '0;
   logic signed [UW-1:0] req_v_top       = '0;
   logic signed [UW-1:0] req_u_right     = '0;
   logic signed [UW-1:0] req_v_bottom    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   logic signed [CW-1:0] rsp_vertex_x;
   logic signed [CW-1:0] rsp_vertex_y;
   logic signed [CW-1:0] rsp_vertex_z;
   logic signed [UW-1:0] rsp_tex_u;
   logic signed [UW-1:0] rsp_tex_v;
   logic [31:0]          rsp_vertex_color;
   logic signed [1:0]    rsp_normal_sign;
   logic [1:0]           rsp_corner;
   logic                 rsp_last;
   logic                 rsp_type_error;

   rotated_quad_vertex_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_center_z     (req_center_z),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .req_angle        (req_angle),
      .req_color_rgba   (req_color_rgba),
      .req_u_left       (req_u_left),
      .req_v_top        (req_v_top),
      .req_u_right      (req_u_right),
      .req_v_bottom     (req_v_bottom),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex_x     (rsp_vertex_x),
      .rsp_vertex_y     (rsp_vertex_y),
      .rsp_vertex_z     (rsp_vertex_z),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_vertex_color (rsp_vertex_color),
      .rsp_normal_sign  (rsp_normal_sign),
      .rsp_corner       (rsp_corner),
      .rsp_last         (rsp_last),
      .rsp_type_error   (rsp_type_error)
   );

   // pending sprites, expected vertices and the predictor's own sprite state
   sprite_req_type       sprite_queue [$];
   vertex_type           expected_vertices [$];
   sprite_req_type       offered;
   rqv_pkg::sprite_type  model_sprite  = rqv_pkg::SPRITE_NONE;
   logic signed [CW-1:0] model_width   = '0;
   logic signed [CW-1:0] model_height  = '0;

   // idling knobs, percent of cycles, changed only at the falling edge
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int cycle_count    = 0;

   // long receiver hold-off for the pressure phase
   logic pressure_on = 1'b0;
   logic hold_done   = 1'b0;
   int   hold_count  = 0;

   // ---------------------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------------------

   // fixed-length cordic, q2.30 cosine and sine of a 16 bit binary angle
   function automatic void rotate_unit(input logic [15:0] ang, output longint cos_q30,
                                       output longint sin_q30);
      logic [31:0] phase;
      logic [31:0] probe;
      logic        flip;
      longint      x;
      longint      y;
      longint      z;
      longint      dx;
      longint      dy;
      longint      step_angle;
      int          steps;
      phase = {ang, 16'h0000};
      probe = phase + 32'h4000_0000;
      flip  = probe[31];
      // fold the left half plane onto the right one, negate at the end
      if (flip) begin
         phase = phase ^ 32'h8000_0000;
      end
      x = GAIN_Q30;
      y = 0;
      z = $signed(phase);
      steps = (STEPS > 24) ? 24 : STEPS;
      for (int i = 0; i < steps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         step_angle = ARCTAN_TURN[i];
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - step_angle;
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + step_angle;
         end
      end
      cos_q30 = flip ? -x : x;
      sin_q30 = flip ? -y : y;
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(input longint v);
      if (v > COORD_MAX) begin
         return COORD_MAX[CW-1:0];
      end else if (v < COORD_MIN) begin
         return COORD_MIN[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   function automatic int sign_of(input longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   // works out the vertices of one accepted sprite and updates the stored sprite
   function automatic void predict_quad(input sprite_req_type s);
      rqv_pkg::sprite_type  want;
      longint               w;
      longint               h;
      longint               cosv;
      longint               sinv;
      longint               wc;
      longint               ws;
      longint               hc;
      longint               hs;
      longint               sx;
      longint               sy;
      logic signed [UW-1:0] ul;
      logic signed [UW-1:0] vt;
      logic signed [UW-1:0] ur;
      logic signed [UW-1:0] vb;
      vertex_type           v;
      want = s.kind[0] ? rqv_pkg::SPRITE_COLOR : rqv_pkg::SPRITE_TEX;
      // update against a different or missing sprite: one error item, state kept
      if (s.kind[1] && model_sprite != want) begin
         v = '0;
         v.last = 1'b1;
         v.type_error = 1'b1;
         expected_vertices.push_back(v);
         return;
      end
      if (!s.kind[1]) begin
         model_sprite = want;
         model_width  = s.width;
         model_height = s.height;
      end
      w = model_width;
      h = model_height;
      if (s.kind[0]) begin
         // colour sprites span the whole unit uv square
         ul = '0;
         vt = '0;
         ur = UW'(1) << (UW - 4);
         vb = UW'(1) << (UW - 4);
      end else begin
         ul = s.ul;
         vt = s.vt;
         ur = s.ur;
         vb = s.vb;
      end
      rotate_unit(s.angle, cosv, sinv);
      wc = w * cosv;
      ws = w * sinv;
      hc = h * cosv;
      hs = h * sinv;
      for (int k = 0; k < 4; k++) begin
         // corners 0,1 sit on the -w side, corners 0,3 on the -h side
         sx = ((k < 2) ? -wc : wc) + ((k == 0 || k == 3) ? -hs : hs);
         sy = ((k < 2) ? ws : -ws) + ((k == 0 || k == 3) ? -hc : hc);
         v = '0;
         v.vertex_x    = clamp_coord(longint'(s.cx) + ((sx + ROUND_HALF) >>> 31));
         v.vertex_y    = clamp_coord(longint'(s.cy) + ((sy + ROUND_HALF) >>> 31));
         v.vertex_z    = s.cz;
         v.tex_u       = (k < 2) ? ul : ur;
         v.tex_v       = (k == 0 || k == 3) ? vb : vt;
         v.color       = s.rgba;
         v.normal_sign = 2'(sign_of(w) * sign_of(h));
         v.corner      = 2'(k);
         v.last        = (k == 3);
         v.type_error  = 1'b0;
         expected_vertices.push_back(v);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic sprite_req_type make_sprite(
         input rqv_pkg::kind_type k, input logic [31:0] cx, input logic [31:0] cy,
         input logic [31:0] cz, input logic [31:0] w, input logic [31:0] h,
         input logic [15:0] ang, input logic [31:0] rgba, input logic [15:0] ul,
         input logic [15:0] vt, input logic [15:0] ur, input logic [15:0] vb);
      sprite_req_type s;
      s.kind   = k;
      s.cx     = cx;
      s.cy     = cy;
      s.cz     = cz;
      s.width  = w;
      s.height = h;
      s.angle  = ang;
      s.rgba   = rgba;
      s.ul     = ul;
      s.vt     = vt;
      s.ur     = ur;
      s.vb     = vb;
      return s;
   endfunction

   // mostly modest q16.16 values, some full range, some at the range edges, zero or minus one
   function automatic logic [31:0] rand_coord();
      logic [31:0] r;
      int          pick;
      r = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         return {{10{r[21]}}, r[21:0]};
      end else if (pick < 8) begin
         return r;
      end
      case (r[1:0])
         2'd0:    return 32'h7FFF_FFFF;
         2'd1:    return 32'h8000_0000;
         2'd2:    return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic sprite_req_type random_sprite(input rqv_pkg::kind_type k);
      logic [31:0] a;
      logic [31:0] b;
      a = $urandom;
      b = $urandom;
      return make_sprite(k, rand_coord(), rand_coord(), $urandom, rand_coord(), rand_coord(),
                         16'($urandom_range(0, 65535)), $urandom,
                         a[15:0], a[31:16], b[15:0], b[31:16]);
   endfunction

   // mostly well-formed create/update sequences, with a share of mismatched updates
   task automatic queue_random(input int count);
      rqv_pkg::sprite_type made;
      rqv_pkg::kind_type   k;
      int                  r;
      made = rqv_pkg::SPRITE_NONE;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            k = rqv_pkg::KIND_CREATE_TEX;
            made = rqv_pkg::SPRITE_TEX;
         end else if (r < 45) begin
            k = rqv_pkg::KIND_CREATE_COLOR;
            made = rqv_pkg::SPRITE_COLOR;
         end else if (r < 88 && made != rqv_pkg::SPRITE_NONE) begin
            k = (made == rqv_pkg::SPRITE_COLOR) ? rqv_pkg::KIND_UPDATE_COLOR :
                                                  rqv_pkg::KIND_UPDATE_TEX;
         end else begin
            k = ($urandom_range(0, 1) != 0) ? rqv_pkg::KIND_UPDATE_COLOR :
                                              rqv_pkg::KIND_UPDATE_TEX;
         end
         sprite_queue.push_back(random_sprite(k));
      end
   endtask

   // waits at falling edges until every sprite is out and every vertex is back
   task automatic wait_drained();
      while (sprite_queue.size() != 0 || req_valid || expected_vertices.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic show_vertex(input string tag, input vertex_type v);
      $display("  %s x=%h y=%h z=%h u=%h v=%h rgba=%h nsign=%b corner=%0d last=%b err=%b",
               tag, v.vertex_x, v.vertex_y, v.vertex_z, v.tex_u, v.tex_v, v.color,
               v.normal_sign, v.corner, v.last, v.type_error);
   endtask

   // ---------------------------------------------------------------------------------------
   // driver: offers queued sprites, keeps an item steady until it is taken
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_quad(offered);
         end
         // the slot is free when nothing is offered or the offer was just taken
         if (!req_valid || req_ready) begin
            if (sprite_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered = sprite_queue.pop_front();
               req_kind        <= offered.kind;
               req_center_x    <= offered.cx;
               req_center_y    <= offered.cy;
               req_center_z    <= offered.cz;
               req_rect_width  <= offered.width;
               req_rect_height <= offered.height;
               req_angle       <= offered.angle;
               req_color_rgba  <= offered.rgba;
               req_u_left      <= offered.ul;
               req_v_top       <= offered.vt;
               req_u_right     <= offered.ur;
               req_v_bottom    <= offered.vb;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // monitor: checks each taken vertex against the oldest expected one
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      vertex_type got;
      vertex_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_vertex_x, rsp_vertex_y, rsp_vertex_z, rsp_tex_u, rsp_tex_v,
                   rsp_vertex_color, rsp_normal_sign, rsp_corner, rsp_last, rsp_type_error};
            if (expected_vertices.size() == 0) begin
               if (fail_count < MAX_REPORTS) begin
                  $display("vertex item with nothing expected at cycle %0d", cycle_count);
                  show_vertex("actual  ", got);
               end
               fail_count++;
            end else begin
               want = expected_vertices.pop_front();
               if (got !== want) begin
                  if (fail_count < MAX_REPORTS) begin
                     $display("vertex item differs at cycle %0d", cycle_count);
                     show_vertex("expected", want);
                     show_vertex("actual  ", got);
                  end
                  fail_count++;
               end
            end
         end
         rsp_ready <= !(pressure_on && !hold_done) &&
                      ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // counts out the long hold-off once the pressure phase starts
   always @(posedge clock) begin
      if (pressure_on && !hold_done) begin
         if (hold_count == HOLD_CYCLES) begin
            hold_done <= 1'b1;
         end else begin
            hold_count <= hold_count + 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rotated_quad_vertex_generator: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // sequence of phases
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, no idling
      // updates before any sprite exists
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_UPDATE_TEX, 0, 0, 0, 32'h0010_0000,
         32'h0010_0000, 16'h0000, 32'h1234_5678, 16'h1000, 16'h2000, 16'h3000, 16'h4000));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_UPDATE_COLOR, 0, 0, 0, 32'h0010_0000,
         32'h0010_0000, 16'h0000, 32'h1234_5678, '0, '0, '0, '0));
      // texture sprite with uv at both ends of the range, then each quadrant boundary
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_CREATE_TEX, 32'h0001_0000,
         32'h0002_0000, 32'h0003_0000, 32'h0040_0000, 32'h0020_0000, 16'h0000,
         32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_UPDATE_TEX, 0, 0, 32'h7FFF_FFFF, 0, 0,
         16'h4000, 32'h0000_00FF, 16'h0001, 16'hFFFF, 16'h1000, 16'h0000));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_UPDATE_TEX, 0, 0, 0, 0, 0,
         16'h8000, 32'h0000_FF00, 16'h0000, 16'h1000, 16'h1000, 16'h0000));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_UPDATE_TEX, 32'hFFFF_0000,
         32'h0000_8000, 0, 0, 0, 16'hC000, 32'h00FF_0000, 16'h0800, 16'h0800, 16'h0C00,
         16'h0C00));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_UPDATE_TEX, 0, 0, 0, 0, 0,
         16'hFFFF, 32'hFF00_0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_UPDATE_TEX, 0, 0, 0, 0, 0,
         16'h3FFF, 32'h8080_8080, 16'h0100, 16'h0200, 16'h0300, 16'h0400));
      // colour update while a texture sprite is stored
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_UPDATE_COLOR, 0, 0, 0, 0, 0,
         16'h1000, 32'h1111_1111, '0, '0, '0, '0));
      // colour sprite with negative width, then its updates
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_CREATE_COLOR, 32'h0010_0000,
         32'hFFF0_0000, 0, 32'hFFF0_0000, 32'h0008_0000, 16'h2000, 32'h0000_0000,
         16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_UPDATE_COLOR, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 16'hBFFF, 32'hA5A5_A5A5, '0, '0, '0, '0));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_UPDATE_TEX, 0, 0, 0, 0, 0,
         16'h0000, 32'h5A5A_5A5A, '0, '0, '0, '0));
      // zero width, then both sizes negative
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_CREATE_TEX, 0, 0, 0, 32'h0000_0000,
         32'h000A_0000, 16'h0800, 32'h0102_0304, 16'h0000, 16'h0000, 16'h1000, 16'h1000));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_CREATE_TEX, 0, 0, 0, 32'hFFFB_0000,
         32'hFFF9_0000, 16'h7000, 32'h0506_0708, 16'h0400, 16'h0C00, 16'h0C00, 16'h0400));
      // saturation in both directions
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_CREATE_COLOR, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1000,
         32'hDEAD_BEEF, '0, '0, '0, '0));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_CREATE_TEX, 32'h8000_0000,
         32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h6000,
         32'hCAFE_F00D, 16'hFFFF, 16'h8000, 16'h0000, 16'h7FFF));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_UPDATE_TEX, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000, 0, 0, 16'hE000, 32'h0F0F_0F0F, 16'h1234, 16'h5678,
         16'h9ABC, 16'hDEF0));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_CREATE_TEX, 0, 0, 0, 0, 0,
         16'h0000, 32'h0000_0000, '0, '0, '0, '0));
      sprite_queue.push_back(make_sprite(rqv_pkg::KIND_CREATE_COLOR, 32'h0000_8000,
         32'h0000_8000, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 16'h8000,
         32'hF0F0_F0F0, 16'h1111, 16'h2222, 16'h3333, 16'h4444));
      wait_drained();

      // random sprites, no idling
      queue_random(45);
      wait_drained();

      // sender idle most of the time
      send_idle_pct = 77;
      queue_random(40);
      wait_drained();

      // receiver stalling most of the time
      send_idle_pct  = 0;
      recv_stall_pct = 77;
      queue_random(40);
      wait_drained();

      // both sides idling
      send_idle_pct  = 34;
      recv_stall_pct = 34;
      queue_random(40);
      wait_drained();

      // receiver holds off for a long stretch while the sender keeps offering
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      pressure_on    = 1'b1;
      queue_random(25);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && expected_vertices.size() == 0) begin
         $display("rotated_quad_vertex_generator: match");
      end else begin
         $display("rotated_quad_vertex_generator: mismatch");
      end
      $finish;
   end

endmodule
